FILE: rtl/core/lphs_pkg.sv
// Shared types and constants for the linear-probe hash set.
package lphs_pkg;

    // Field widths
    localparam int KEY_W  = 31;
    localparam int SLOT_W = 10;
    localparam int TS_W   = 11;
    localparam int OP_W   = 2;

    // Width of the bit-step counter of the remainder unit
    localparam int DCNT_W = $clog2(KEY_W);

    // Table size after reset
    localparam logic [TS_W-1:0] TS_RESET = 11'd1024;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_FIND   = 2'd1,
        OP_DELETE = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PRB_RD,
        ST_PRB_CHK,
        ST_CG_RD,
        ST_CG_CHK,
        ST_CG_DIV,
        ST_CG_MOVE,
        ST_CG_END
    } state_t;

endpackage

FILE: rtl/core/linear_probe_hash_set_core.sv
// Linear-probe hash set with backward-shift delete, table held in one synchronous memory.
// Operation: the home slot is a bit-serial remainder of the key by the table size, then each
//   probed slot is read and then checked; done pulses after the final check, opcode 3 from idle.
// Delete then walks the cluster, rehashing each occupied slot, and ends by clearing the last gap.
// Throughput: one operation at a time; busy is high until the cycle that done pulses.
// Reset: a clearing pass walks the memory one entry per cycle (busy high);
//   table_size returns to 1024. done is a one-cycle strobe that the receiver cannot stall.
module linear_probe_hash_set_core #(
    parameter int CAPACITY = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          table_size_we,
    input  logic [lphs_pkg::TS_W-1:0]     table_size,
    input  logic                          start,
    output logic                          busy,
    input  logic [lphs_pkg::OP_W-1:0]     opcode,
    input  logic [lphs_pkg::KEY_W-1:0]    key,
    output logic                          done,
    output logic                          hit,
    output logic [lphs_pkg::SLOT_W-1:0]   slot,
    output logic                          table_full
);
    import lphs_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int NW = AW + 1;
    localparam int CW = (NW > TS_W) ? NW : TS_W;

    // Table memory: valid bit over key
    logic [KEY_W:0] key_mem [CAPACITY];
    logic [KEY_W:0] rd_data_reg;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [KEY_W:0]   mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;

    state_t state_reg, state_next;

    logic [TS_W-1:0]   table_size_reg;
    logic [AW-1:0]     clr_reg, clr_next;
    logic              done_reg, done_next;
    logic              hit_reg, hit_next;
    logic              full_reg, full_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    op_t               op_reg, op_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [KEY_W-1:0]  mkey_reg, mkey_next;
    logic [KEY_W-1:0]  div_num_reg, div_num_next;
    logic [NW-1:0]     div_rem_reg, div_rem_next;
    logic [DCNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [AW-1:0]     b_reg, b_next;
    logic [AW-1:0]     gap_reg, gap_next;
    logic [NW-1:0]     cnt_reg, cnt_next;

    logic [CW-1:0]     ts_ext;
    logic [CW-1:0]     n_wide;
    logic [NW-1:0]     n;
    logic [NW:0]       div_r2;
    logic [NW:0]       div_sub;
    logic [NW-1:0]     div_rem_step;
    logic              div_last;
    logic [NW-1:0]     b_inc;
    logic [AW-1:0]     b_wrap;
    logic              probe_last;
    logic              rd_valid;
    logic [KEY_W-1:0]  rd_key;
    logic              key_match;
    logic              slot_live;
    logic              clr_last;
    logic [AW-1:0]     home;
    logic              do_move;

    // Distance walked around the ring from one slot to another
    function automatic logic [NW-1:0] ring_dist(
        input logic [AW-1:0] from_s,
        input logic [AW-1:0] to_s,
        input logic [NW-1:0] size
    );
        logic [NW-1:0] d;
        if (to_s >= from_s)
            d = NW'(to_s) - NW'(from_s);
        else
            d = NW'(to_s) + size - NW'(from_s);
        return d;
    endfunction

    // Clamp the table size into 1..CAPACITY
    assign ts_ext = CW'(table_size_reg);
    assign n_wide = (ts_ext == '0) ? CW'(1) :
                    ((ts_ext > CW'(CAPACITY)) ? CW'(CAPACITY) : ts_ext);
    assign n      = NW'(n_wide);

    // One restoring step of key modulo table size
    assign div_r2       = {div_rem_reg, div_num_reg[KEY_W-1]};
    assign div_sub      = (div_r2 >= {1'b0, n}) ? (div_r2 - {1'b0, n}) : div_r2;
    assign div_rem_step = NW'(div_sub);
    assign div_last     = (div_cnt_reg == DCNT_W'(KEY_W - 1));

    // Probe address advance with wrap at the table size
    assign b_inc      = NW'(b_reg) + NW'(1);
    assign b_wrap     = (b_inc == n) ? '0 : AW'(b_inc);
    assign probe_last = ((cnt_reg + NW'(1)) == n);

    // Read data; the pending gap of a delete reads as empty
    assign rd_valid  = rd_data_reg[KEY_W];
    assign rd_key    = rd_data_reg[KEY_W-1:0];
    assign key_match = (rd_key == key_reg);
    assign slot_live = rd_valid && (b_reg != gap_reg);
    assign clr_last  = (clr_reg == AW'(CAPACITY - 1));

    // Shift a member back when its home is not in the ring span from just past the gap up to the slot itself
    assign home    = AW'(div_rem_reg);
    assign do_move = (ring_dist(home, b_reg, n) >= ring_dist(gap_reg, b_reg, n));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start && (op_t'(opcode) != OP_NOP))
                    state_next = ST_HASH;
            end
            ST_HASH:
            begin
                if (div_last)
                    state_next = ST_PRB_RD;
            end
            ST_PRB_RD:
                state_next = ST_PRB_CHK;
            ST_PRB_CHK:
            begin
                if (!rd_valid)
                    state_next = ST_IDLE;
                else if (key_match)
                    state_next = (op_reg == OP_DELETE) ? ST_CG_RD : ST_IDLE;
                else if (probe_last)
                    state_next = ST_IDLE;
                else
                    state_next = ST_PRB_RD;
            end
            ST_CG_RD:
                state_next = (cnt_reg == n) ? ST_CG_END : ST_CG_CHK;
            ST_CG_CHK:
                state_next = slot_live ? ST_CG_DIV : ST_CG_END;
            ST_CG_DIV:
            begin
                if (div_last)
                    state_next = ST_CG_MOVE;
            end
            ST_CG_MOVE:
                state_next = ST_CG_RD;
            ST_CG_END:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath, memory control and result
    always_comb
    begin
        clr_next     = clr_reg;
        done_next    = 1'b0;
        hit_next     = hit_reg;
        full_next    = full_reg;
        slot_next    = slot_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        mkey_next    = mkey_reg;
        div_num_next = div_num_reg;
        div_rem_next = div_rem_reg;
        div_cnt_next = div_cnt_reg;
        b_next       = b_reg;
        gap_next     = gap_reg;
        cnt_next     = cnt_reg;
        mem_we       = 1'b0;
        mem_waddr    = gap_reg;
        mem_wdata    = '0;
        mem_re       = 1'b0;
        mem_raddr    = b_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + AW'(1);
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next      = op_t'(opcode);
                    key_next     = key;
                    div_num_next = key;
                    div_rem_next = '0;
                    div_cnt_next = '0;
                    gap_next     = '0;
                    if (op_t'(opcode) == OP_NOP)
                    begin
                        done_next = 1'b1;
                        hit_next  = 1'b0;
                        full_next = 1'b0;
                        slot_next = '0;
                    end
                end
            end
            ST_HASH:
            begin
                div_num_next = div_num_reg << 1;
                div_rem_next = div_rem_step;
                div_cnt_next = div_cnt_reg + DCNT_W'(1);
                if (div_last)
                begin
                    b_next   = AW'(div_rem_step);
                    cnt_next = '0;
                end
            end
            ST_PRB_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = b_reg;
            end
            ST_PRB_CHK:
            begin
                if (!rd_valid)
                begin
                    done_next = 1'b1;
                    hit_next  = 1'b0;
                    full_next = 1'b0;
                    slot_next = '0;
                    if (op_reg == OP_INSERT)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = b_reg;
                        mem_wdata = {1'b1, key_reg};
                        slot_next = SLOT_W'(b_reg);
                    end
                end
                else if (key_match)
                begin
                    hit_next  = 1'b1;
                    full_next = 1'b0;
                    slot_next = SLOT_W'(b_reg);
                    if (op_reg == OP_DELETE)
                    begin
                        gap_next = b_reg;
                        b_next   = b_wrap;
                        cnt_next = '0;
                    end
                    else
                        done_next = 1'b1;
                end
                else if (probe_last)
                begin
                    done_next = 1'b1;
                    hit_next  = 1'b0;
                    slot_next = '0;
                    full_next = (op_reg == OP_INSERT);
                end
                else
                begin
                    b_next   = b_wrap;
                    cnt_next = cnt_reg + NW'(1);
                end
            end
            ST_CG_RD:
            begin
                mem_re    = (cnt_reg != n);
                mem_raddr = b_reg;
            end
            ST_CG_CHK:
            begin
                if (slot_live)
                begin
                    mkey_next    = rd_key;
                    div_num_next = rd_key;
                    div_rem_next = '0;
                    div_cnt_next = '0;
                end
            end
            ST_CG_DIV:
            begin
                div_num_next = div_num_reg << 1;
                div_rem_next = div_rem_step;
                div_cnt_next = div_cnt_reg + DCNT_W'(1);
            end
            ST_CG_MOVE:
            begin
                if (do_move)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = gap_reg;
                    mem_wdata = {1'b1, mkey_reg};
                    gap_next  = b_reg;
                end
                b_next   = b_wrap;
                cnt_next = cnt_reg + NW'(1);
            end
            ST_CG_END:
            begin
                // Retire the last gap as empty
                mem_we    = 1'b1;
                mem_waddr = gap_reg;
                mem_wdata = '0;
                done_next = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            done_reg       <= 1'b0;
            table_size_reg <= TS_RESET;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
            if (table_size_we)
                table_size_reg <= table_size;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        hit_reg     <= hit_next;
        full_reg    <= full_next;
        slot_reg    <= slot_next;
        op_reg      <= op_next;
        key_reg     <= key_next;
        mkey_reg    <= mkey_next;
        div_num_reg <= div_num_next;
        div_rem_reg <= div_rem_next;
        div_cnt_reg <= div_cnt_next;
        b_reg       <= b_next;
        gap_reg     <= gap_next;
        cnt_reg     <= cnt_next;
    end

    // Table memory write port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            key_mem[mem_waddr] <= mem_wdata;
    end

    // Table memory read port, registered
    always_ff @(posedge clk)
    begin
        if (mem_re)
            rd_data_reg <= key_mem[mem_raddr];
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign hit        = hit_reg;
    assign slot       = slot_reg;
    assign table_full = full_reg;

endmodule

FILE: rtl/core/lphs_checker.sv
// Port-level checks for the linear-probe hash set, bound to the top level.
module lphs_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic [lphs_pkg::OP_W-1:0]    opcode,
    input logic                         done,
    input logic                         hit,
    input logic [lphs_pkg::SLOT_W-1:0]  slot,
    input logic                         table_full
);
    import lphs_pkg::*;

    // A failed insert reports no hit and slot zero
    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && table_full) |-> (!hit && (slot == '0)))
        else $error("table_full result carries hit or slot");

    // A no-op transfer answers in the next cycle with an empty result
    a_nop_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (opcode == OP_NOP)) |=>
            (done && !hit && !table_full && (slot == '0)))
        else $error("no-op did not return an empty result");

    // A result follows only a transfer or a running operation
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || start))
        else $error("result without a preceding transfer");

    // The clearing pass holds the block busy right after reset
    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> (busy && !done))
        else $error("block not busy after reset");

endmodule

bind linear_probe_hash_set_core lphs_checker u_lphs_checker (.*);
